// File: hdl/fm_polar_discriminator_unit_macros.svh
// assertion helpers shared by the discriminator
`ifndef FM_POLAR_DISCRIMINATOR_UNIT_MACROS_SVH
`define FM_POLAR_DISCRIMINATOR_UNIT_MACROS_SVH

// same-cycle implication, checking stops while reset is low
`define FMPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("fmpd assertion failed");

// next-cycle implication
`define FMPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("fmpd assertion failed");

`endif

// File: hdl/fmpd_pkg.sv
`timescale 1ns / 1ps
package fmpd_pkg;

	localparam int unsigned SAMPLE_W_DEF = 16;
	localparam int unsigned ANGLE_W_DEF  = 16;
	localparam int unsigned FIELD_W      = 16;

	// x/y datapath: integer lsb, samples scaled to 2^31, gain and sqrt2 headroom
	localparam int unsigned XY_W       = 36;
	localparam int unsigned DIG_W      = 18;
	localparam int unsigned NDIG       = XY_W / DIG_W;
	localparam int unsigned DIG_IDX_W  = $clog2(NDIG);
	localparam int unsigned Z_W        = 32;
	localparam int unsigned ZDIG_W     = Z_W / NDIG;
	localparam int unsigned ATAN_LEN   = 24;
	localparam int unsigned ATAN_IDX_W = 5;

	typedef struct packed {
		logic idle;
		logic done;
	} fmpd_stat_t;

	// atan(2^-k), 2^31 = pi
	function automatic logic [Z_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] k);
		logic [Z_W-1:0] v;
		unique case (k)
			5'd0:    v = 32'h2000_0000;
			5'd1:    v = 32'h12E4_051E;
			5'd2:    v = 32'h09FB_385B;
			5'd3:    v = 32'h0511_11D4;
			5'd4:    v = 32'h028B_0D43;
			5'd5:    v = 32'h0145_D7E1;
			5'd6:    v = 32'h00A2_F61E;
			5'd7:    v = 32'h0051_7C55;
			5'd8:    v = 32'h0028_BE53;
			5'd9:    v = 32'h0014_5F2F;
			5'd10:   v = 32'h000A_2F98;
			5'd11:   v = 32'h0005_17CC;
			5'd12:   v = 32'h0002_8BE6;
			5'd13:   v = 32'h0001_45F3;
			5'd14:   v = 32'h0000_A2FA;
			5'd15:   v = 32'h0000_517D;
			5'd16:   v = 32'h0000_28BE;
			5'd17:   v = 32'h0000_145F;
			5'd18:   v = 32'h0000_0A30;
			5'd19:   v = 32'h0000_0518;
			5'd20:   v = 32'h0000_028C;
			5'd21:   v = 32'h0000_0146;
			5'd22:   v = 32'h0000_00A3;
			5'd23:   v = 32'h0000_0051;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: hdl/fmpd_iq_if.sv
`timescale 1ns / 1ps
interface fmpd_iq_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [fmpd_pkg::FIELD_W-1:0] i_sample;
	logic signed [fmpd_pkg::FIELD_W-1:0] q_sample;

	modport source (output valid, output i_sample, output q_sample, input ready);
	modport sink (input valid, input i_sample, input q_sample, output ready);
endinterface

// File: hdl/fmpd_delta_if.sv
`timescale 1ns / 1ps
interface fmpd_delta_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [fmpd_pkg::FIELD_W-1:0] phase_delta;

	modport source (output valid, output phase_delta, input ready);
	modport sink (input valid, input phase_delta, output ready);
endinterface

// File: hdl/fm_polar_discriminator_unit.sv
// fm polar discriminator: binary angle of each iq sample by a digit-serial cordic,
// output is the wrapped difference to the previous angle.
// a zero iq sample skips the rotations and gives angle zero.
// one sample at a time: a new beat is taken only after the last result is handed on.
// the shared cordic step does two 18-bit digits per micro-rotation; outputs may wait meanwhile.
// reset: arst_n clears control, valids and the previous angle to zero.
`timescale 1ns / 1ps
`include "fm_polar_discriminator_unit_macros.svh"
module fm_polar_discriminator_unit #(
	parameter int unsigned SAMPLE_WIDTH = fmpd_pkg::SAMPLE_W_DEF,
	parameter int unsigned ANGLE_WIDTH  = fmpd_pkg::ANGLE_W_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	fmpd_iq_if.sink       iq,
	fmpd_delta_if.source  demod
);

	localparam int unsigned FIELD_W = fmpd_pkg::FIELD_W;

	logic signed [SAMPLE_WIDTH-1:0] xi, yi;
	fmpd_pkg::fmpd_stat_t           stat;
	logic [ANGLE_WIDTH-1:0]         angle;
	logic [ANGLE_WIDTH-1:0]         prev_angle_q;
	logic [ANGLE_WIDTH-1:0]         delta_q;
	logic                           out_valid_q;
	logic                           start, ack;

	// sample bits above SAMPLE_WIDTH are dropped, missing ones read as zero
	if (SAMPLE_WIDTH <= FIELD_W) begin : g_in_trunc
		assign xi = iq.i_sample[SAMPLE_WIDTH-1:0];
		assign yi = iq.q_sample[SAMPLE_WIDTH-1:0];
	end else begin : g_in_ext
		assign xi = {{(SAMPLE_WIDTH-FIELD_W){1'b0}}, iq.i_sample};
		assign yi = {{(SAMPLE_WIDTH-FIELD_W){1'b0}}, iq.q_sample};
	end

	assign iq.ready = stat.idle;
	assign start    = iq.valid & stat.idle;
	assign ack      = stat.done & (~out_valid_q | demod.ready);

	fmpd_cordic #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.ANGLE_WIDTH (ANGLE_WIDTH)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.xi    (xi),
		.yi    (yi),
		.ack   (ack),
		.stat  (stat),
		.angle (angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			prev_angle_q <= '0;
		end else begin
			if (ack) begin
				out_valid_q  <= 1'b1;
				prev_angle_q <= angle;
			end else if (demod.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// modular difference, exactly pi comes out as minus pi
	always_ff @(posedge clk) begin
		if (ack) begin
			delta_q <= angle - prev_angle_q;
		end
	end

	assign demod.valid = out_valid_q;

	if (ANGLE_WIDTH >= FIELD_W) begin : g_out_trunc
		assign demod.phase_delta = delta_q[FIELD_W-1:0];
	end else begin : g_out_ext
		assign demod.phase_delta = {{(FIELD_W-ANGLE_WIDTH){1'b0}}, delta_q};
	end

	`FMPD_ASSERT_NEXT(a_start_busy, clk, arst_n, iq.valid && iq.ready, !stat.idle)
	`FMPD_ASSERT_NOW(a_idle_done_excl, clk, arst_n, stat.done, !stat.idle)
	`FMPD_ASSERT_NEXT(a_done_drains, clk, arst_n, stat.done && !out_valid_q, out_valid_q)

endmodule

// File: hdl/fmpd_cordic.sv
`timescale 1ns / 1ps
module fmpd_cordic #(
	parameter int unsigned SAMPLE_WIDTH = fmpd_pkg::SAMPLE_W_DEF,
	parameter int unsigned ANGLE_WIDTH  = fmpd_pkg::ANGLE_W_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [SAMPLE_WIDTH-1:0] xi,
	input  logic signed [SAMPLE_WIDTH-1:0] yi,
	input  logic                           ack,
	output fmpd_pkg::fmpd_stat_t           stat,
	output logic [ANGLE_WIDTH-1:0]         angle
);

	localparam int unsigned XY_W   = fmpd_pkg::XY_W;
	localparam int unsigned DIG_W  = fmpd_pkg::DIG_W;
	localparam int unsigned Z_W    = fmpd_pkg::Z_W;
	localparam int unsigned ZDIG_W = fmpd_pkg::ZDIG_W;
	localparam int unsigned STEPS  =
		(ANGLE_WIDTH < fmpd_pkg::ATAN_LEN) ? ANGLE_WIDTH : fmpd_pkg::ATAN_LEN;
	localparam int unsigned STEP_W = $clog2(STEPS);
	localparam int unsigned SHIFT  = 32 - SAMPLE_WIDTH;
	localparam logic [Z_W-1:0] HALF   = Z_W'(1) << (Z_W - 1 - ANGLE_WIDTH);
	localparam logic [Z_W-1:0] Z_PI   = Z_W'(1) << (Z_W - 1);
	localparam logic [fmpd_pkg::DIG_IDX_W-1:0] DIG_LAST =
		fmpd_pkg::DIG_IDX_W'(fmpd_pkg::NDIG - 1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

	typedef enum logic [1:0] {S_IDLE, S_ROT, S_RND, S_DONE} state_t;

	state_t                            state_q;
	logic [STEP_W-1:0]                 k_q;
	logic [fmpd_pkg::DIG_IDX_W-1:0]    dig_q;
	logic                              cx_q, cy_q, cz_q;
	logic signed [XY_W-1:0]            x_q, y_q;
	logic [XY_W-1:0]                   xn_q, yn_q;
	logic [Z_W-1:0]                    z_q, zn_q;
	logic                              zero_q;
	logic [ANGLE_WIDTH-1:0]            angle_q;

	logic signed [XY_W-1:0] xs, ys, xl, yl, xsh, ysh;
	logic                   neg, pos, first_dig, last_dig;
	logic [DIG_W-1:0]       xd, yd, xdig, ydig, ox, oy;
	logic [ZDIG_W-1:0]      zdig, ad, oz;
	logic [Z_W-1:0]         aw, zr;
	logic                   cin_x, cin_y, cin_z;
	logic [DIG_W:0]         sum_x, sum_y;
	logic [ZDIG_W:0]        sum_z;

	// pre-rotation into the right half plane, done on the sample extended to the datapath width before scaling
	assign xs  = XY_W'(xi);
	assign ys  = XY_W'(yi);
	assign neg = xs[XY_W-1];
	assign xl  = neg ? -xs : xs;
	assign yl  = neg ? -ys : ys;

	// one digit of each update per cycle, lsb digit first
	assign pos       = ~y_q[XY_W-1];
	assign first_dig = (dig_q == '0);
	assign last_dig  = (dig_q == DIG_LAST);
	assign xsh       = x_q >>> k_q;
	assign ysh       = y_q >>> k_q;
	assign xd        = xsh[dig_q*DIG_W +: DIG_W];
	assign yd        = ysh[dig_q*DIG_W +: DIG_W];
	assign xdig      = x_q[dig_q*DIG_W +: DIG_W];
	assign ydig      = y_q[dig_q*DIG_W +: DIG_W];
	assign aw        = fmpd_pkg::atan_lut(fmpd_pkg::ATAN_IDX_W'(k_q));
	assign ad        = aw[dig_q*ZDIG_W +: ZDIG_W];
	assign zdig      = z_q[dig_q*ZDIG_W +: ZDIG_W];

	// subtraction as inverted operand with carry-in on the first digit
	assign ox    = pos ? yd : ~yd;
	assign oy    = pos ? ~xd : xd;
	assign oz    = pos ? ad : ~ad;
	assign cin_x = first_dig ? ~pos : cx_q;
	assign cin_y = first_dig ? pos : cy_q;
	assign cin_z = first_dig ? ~pos : cz_q;
	assign sum_x = {1'b0, xdig} + {1'b0, ox} + (DIG_W+1)'(cin_x);
	assign sum_y = {1'b0, ydig} + {1'b0, oy} + (DIG_W+1)'(cin_y);
	assign sum_z = {1'b0, zdig} + {1'b0, oz} + (ZDIG_W+1)'(cin_z);

	assign zr = z_q + HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			dig_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					k_q   <= '0;
					dig_q <= '0;
					if (start) begin
						// a zero sample skips the rotations
						state_q <= (xi == '0 && yi == '0) ? S_RND : S_ROT;
					end
				end
				S_ROT: begin
					if (last_dig) begin
						dig_q <= '0;
						k_q   <= k_q + STEP_W'(1);
						if (k_q == STEP_LAST) begin
							state_q <= S_RND;
						end
					end else begin
						dig_q <= dig_q + fmpd_pkg::DIG_IDX_W'(1);
					end
				end
				S_RND: state_q <= S_DONE;
				S_DONE: begin
					if (ack) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			x_q    <= xl <<< SHIFT;
			y_q    <= yl <<< SHIFT;
			z_q    <= neg ? Z_PI : '0;
			zero_q <= (xi == '0 && yi == '0);
		end else if (state_q == S_ROT) begin
			cx_q <= sum_x[DIG_W];
			cy_q <= sum_y[DIG_W];
			cz_q <= sum_z[ZDIG_W];
			xn_q <= {sum_x[DIG_W-1:0], xn_q[XY_W-1:DIG_W]};
			yn_q <= {sum_y[DIG_W-1:0], yn_q[XY_W-1:DIG_W]};
			zn_q <= {sum_z[ZDIG_W-1:0], zn_q[Z_W-1:ZDIG_W]};
			if (last_dig) begin
				x_q <= {sum_x[DIG_W-1:0], xn_q[XY_W-1:DIG_W]};
				y_q <= {sum_y[DIG_W-1:0], yn_q[XY_W-1:DIG_W]};
				z_q <= {sum_z[ZDIG_W-1:0], zn_q[Z_W-1:ZDIG_W]};
			end
		end else if (state_q == S_RND) begin
			// round half up, wraps with the angle
			angle_q <= zero_q ? '0 : zr[Z_W-1 -: ANGLE_WIDTH];
		end
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_DONE);
	assign angle     = angle_q;

endmodule
